// File: hdl/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared codes and types for the passive serial configuration unit.
// ----------------------------------------------------------------------------
package fpsc_pkg;

   typedef logic [1:0] op_type;
   typedef logic [2:0] code_type;
   typedef logic [2:0] csr_index_type;

   // request operations
   localparam op_type OP_START  = 2'd1;
   localparam op_type OP_WORD   = 2'd2;
   localparam op_type OP_FINISH = 2'd3;

   // result codes
   localparam code_type RC_IDLE      = 3'd0;
   localparam code_type RC_BUSY      = 3'd1;
   localparam code_type RC_OK        = 3'd2;
   localparam code_type RC_START_ERR = 3'd3;
   localparam code_type RC_DATA_ERR  = 3'd4;
   localparam code_type RC_END_ERR   = 3'd5;

   // configuration register indexes
   localparam csr_index_type CSR_SETTLE         = 3'd0;
   localparam csr_index_type CSR_PULSE          = 3'd1;
   localparam csr_index_type CSR_STATUS_TIMEOUT = 3'd2;
   localparam csr_index_type CSR_INIT_TIMEOUT   = 3'd3;
   localparam csr_index_type CSR_PRESTREAM      = 3'd4;

   localparam int CSR_DATA_WIDTH = 20;

   // configuration reset values
   localparam logic [19:0] SETTLE_RESET         = 20'd10000;
   localparam logic [7:0]  PULSE_RESET          = 8'd1;
   localparam logic [15:0] STATUS_TIMEOUT_RESET = 16'd230;
   localparam logic [15:0] INIT_TIMEOUT_RESET   = 16'd650;
   localparam logic [7:0]  PRESTREAM_RESET      = 8'd2;

endpackage

// File: hdl/fpga_passive_serial_config_unit.sv
// ----------------------------------------------------------------------------
// fpga_passive_serial_config_unit
// Passive serial configuration master, advanced one timebase tick per
// request transaction.
// ----------------------------------------------------------------------------
// Each request transaction is one tick: it carries the sampled nSTATUS,
// CONF_DONE and INIT_DONE levels and an operation (tick, start, word,
// finish). Each request gives exactly one response transaction with the pin
// levels to drive after that tick, the word_ready flag, the result code,
// the byte count and the early CONF_DONE flag.
// The tick is evaluated in the accepting cycle and the response register holds
// the result from the next cycle on. Throughput is one transaction per cycle
// while no stalled response is held; the state update and the response
// register are the only stages.
// req_stall is high only while a response is held and rsp_stall is high, so
// a stalled response freezes both the response and the sequencer state.
// The csr_ port writes timing registers; write only while no transaction is
// in flight.
// Synchronous reset loads the default timing values, puts the sequencer in
// idle with code idle, zero byte count and the mode pins released, and
// empties the response register.
// ----------------------------------------------------------------------------
module fpga_passive_serial_config_unit #(
   parameter int WORD_BITS   = 32,
   parameter int COUNT_WIDTH = 24,
   parameter int TIMER_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic [WORD_BITS-1:0]                  req_data_word,
   input  logic                                  req_nstatus_level,
   input  logic                                  req_confdone_level,
   input  logic                                  req_initdone_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_nconfig_drive,
   output logic                                  rsp_dclk_drive,
   output logic                                  rsp_data_drive,
   output logic                                  rsp_msel_enable,
   output logic                                  rsp_word_ready,
   output logic [2:0]                            rsp_result_code,
   output logic [COUNT_WIDTH-1:0]                rsp_bytes_sent,
   output logic                                  rsp_early_done,
   input  logic                                  csr_wr_en,
   input  logic [2:0]                            csr_index,
   input  logic [fpsc_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data
);

   localparam int BIT_W          = $clog2(WORD_BITS);
   localparam int BYTES_PER_WORD = WORD_BITS / 8;
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_BITS - 1);
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [32:0] TIMER_MAX_EXT = 33'(TIMER_MAX);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [3:0] PH_IDLE        = 4'd0;
   localparam logic [3:0] PH_SETTLE_PRE  = 4'd1;
   localparam logic [3:0] PH_PULSE       = 4'd2;
   localparam logic [3:0] PH_CHECK_LOW   = 4'd3;
   localparam logic [3:0] PH_WAIT_STATUS = 4'd4;
   localparam logic [3:0] PH_PRESTREAM   = 4'd5;
   localparam logic [3:0] PH_READY       = 4'd6;
   localparam logic [3:0] PH_SHIFT       = 4'd7;
   localparam logic [3:0] PH_DRAINED     = 4'd8;
   localparam logic [3:0] PH_WAIT_INIT   = 4'd9;
   localparam logic [3:0] PH_SETTLE_POST = 4'd10;

   // timing registers
   logic [19:0] settle_ff;
   logic [7:0]  pulse_ff;
   logic [15:0] status_to_ff;
   logic [15:0] init_to_ff;
   logic [7:0]  prestream_ff;

   // sequencer state
   logic [3:0]                 phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]     timer_ff, timer_in;
   logic [WORD_BITS-1:0]       shift_ff, shift_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic                       clk_ff, clk_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   fpsc_pkg::code_type         code_ff, code_in;
   logic                       msel_ff, msel_in;
   logic                       early_ff, early_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       nconfig_ff, nconfig_in;
   logic                       dclk_ff, dclk_in;
   logic                       data_ff, data_in;
   logic                       msel_out_ff;
   logic                       ready_ff, ready_in;
   fpsc_pkg::code_type         rcode_ff, rcode_in;
   logic [COUNT_WIDTH-1:0]     bytes_ff;
   logic                       early_out_ff;

   logic                       req_accept;
   fpsc_pkg::op_type           op;
   logic [TIMER_WIDTH-1:0]     timer_inc;
   logic [19:0]                target;
   logic [32:0]                target_lim;
   logic                       reach;
   logic [COUNT_WIDTH:0]       count_sum;
   logic [COUNT_WIDTH-1:0]     count_sat;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign op         = req_operation;

   // saturating wait timer and its limited target
   always_comb begin
      timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + TIMER_WIDTH'(1);
      unique case (phase_ff)
         PH_SETTLE_PRE, PH_SETTLE_POST: target = settle_ff;
         PH_PULSE:                      target = 20'(pulse_ff);
         PH_WAIT_STATUS:                target = 20'(status_to_ff);
         PH_PRESTREAM:                  target = 20'(prestream_ff);
         PH_WAIT_INIT:                  target = 20'(init_to_ff);
         default:                       target = '0;
      endcase
      target_lim = (33'(target) > TIMER_MAX_EXT) ? TIMER_MAX_EXT : 33'(target);
      reach      = 33'(timer_inc) >= target_lim;
      count_sum  = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(BYTES_PER_WORD);
      count_sat  = count_sum[COUNT_WIDTH] ? COUNT_MAX : count_sum[COUNT_WIDTH-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      clk_in   = clk_ff;
      count_in = count_ff;
      code_in  = code_ff;
      msel_in  = msel_ff;
      early_in = early_ff;
      if (op == fpsc_pkg::OP_START) begin
         count_in = '0;
         early_in = 1'b0;
         clk_in   = 1'b0;
         bit_in   = '0;
         msel_in  = 1'b1;
         timer_in = '0;
         phase_in = (settle_ff == '0) ? PH_PULSE : PH_SETTLE_PRE;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_SETTLE_PRE: begin
               timer_in = timer_inc;
               if (reach) begin
                  phase_in = PH_PULSE;
                  timer_in = '0;
               end
            end
            PH_PULSE: begin
               timer_in = timer_inc;
               if (reach) begin
                  phase_in = PH_CHECK_LOW;
                  timer_in = '0;
               end
            end
            PH_CHECK_LOW: begin
               timer_in = '0;
               if (req_nstatus_level) begin
                  phase_in = PH_IDLE;
                  clk_in   = 1'b0;
                  code_in  = fpsc_pkg::RC_START_ERR;
               end else begin
                  phase_in = PH_WAIT_STATUS;
               end
            end
            PH_WAIT_STATUS: begin
               if (req_nstatus_level) begin
                  timer_in = '0;
                  if (req_confdone_level) begin
                     phase_in = PH_IDLE;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_START_ERR;
                  end else begin
                     phase_in = (prestream_ff == '0) ? PH_READY : PH_PRESTREAM;
                  end
               end else begin
                  timer_in = timer_inc;
                  if (reach) begin
                     phase_in = PH_IDLE;
                     timer_in = '0;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_START_ERR;
                  end
               end
            end
            PH_PRESTREAM: begin
               timer_in = timer_inc;
               if (reach) begin
                  phase_in = PH_READY;
                  timer_in = '0;
               end
            end
            PH_READY: begin
               if (op == fpsc_pkg::OP_WORD) begin
                  timer_in = '0;
                  if (req_confdone_level) begin
                     if (count_ff == '0) begin
                        phase_in = PH_IDLE;
                        clk_in   = 1'b0;
                        code_in  = fpsc_pkg::RC_DATA_ERR;
                     end else begin
                        early_in = 1'b1;
                        phase_in = PH_DRAINED;
                     end
                  end else begin
                     shift_in = req_data_word;
                     bit_in   = '0;
                     clk_in   = 1'b0;
                     phase_in = PH_SHIFT;
                  end
               end else if (op == fpsc_pkg::OP_FINISH) begin
                  timer_in = '0;
                  if (req_confdone_level) begin
                     phase_in = PH_WAIT_INIT;
                  end else begin
                     phase_in = PH_IDLE;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_END_ERR;
                  end
               end
            end
            PH_SHIFT: begin
               if (!clk_ff) begin
                  clk_in = 1'b1;
               end else begin
                  clk_in = 1'b0;
                  if (bit_ff == LAST_BIT) begin
                     bit_in   = '0;
                     count_in = count_sat;
                     phase_in = PH_READY;
                     timer_in = '0;
                  end else begin
                     bit_in = bit_ff + BIT_W'(1);
                  end
               end
            end
            PH_DRAINED: begin
               if (op == fpsc_pkg::OP_FINISH) begin
                  timer_in = '0;
                  if (req_confdone_level) begin
                     phase_in = PH_WAIT_INIT;
                  end else begin
                     phase_in = PH_IDLE;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_END_ERR;
                  end
               end
            end
            PH_WAIT_INIT: begin
               if (req_initdone_level) begin
                  timer_in = '0;
                  if (settle_ff == '0) begin
                     msel_in  = 1'b0;
                     phase_in = PH_IDLE;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_OK;
                  end else begin
                     phase_in = PH_SETTLE_POST;
                  end
               end else begin
                  timer_in = timer_inc;
                  if (reach) begin
                     phase_in = PH_IDLE;
                     timer_in = '0;
                     clk_in   = 1'b0;
                     code_in  = fpsc_pkg::RC_END_ERR;
                  end
               end
            end
            PH_SETTLE_POST: begin
               timer_in = timer_inc;
               if (reach) begin
                  msel_in  = 1'b0;
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  clk_in   = 1'b0;
                  code_in  = fpsc_pkg::RC_OK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // response fields from the post-tick state
   always_comb begin
      nconfig_in   = phase_in != PH_PULSE;
      dclk_in      = (phase_in == PH_SHIFT) & clk_in;
      data_in      = (phase_in == PH_SHIFT) & shift_in[bit_in];
      ready_in     = (phase_in == PH_READY) | (phase_in == PH_DRAINED);
      rcode_in     = (phase_in == PH_IDLE) ? code_in : fpsc_pkg::RC_BUSY;
      rsp_valid_in = req_accept ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= fpsc_pkg::SETTLE_RESET;
         pulse_ff     <= fpsc_pkg::PULSE_RESET;
         status_to_ff <= fpsc_pkg::STATUS_TIMEOUT_RESET;
         init_to_ff   <= fpsc_pkg::INIT_TIMEOUT_RESET;
         prestream_ff <= fpsc_pkg::PRESTREAM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fpsc_pkg::CSR_SETTLE:         settle_ff    <= csr_wr_data;
            fpsc_pkg::CSR_PULSE:          pulse_ff     <= csr_wr_data[7:0];
            fpsc_pkg::CSR_STATUS_TIMEOUT: status_to_ff <= csr_wr_data[15:0];
            fpsc_pkg::CSR_INIT_TIMEOUT:   init_to_ff   <= csr_wr_data[15:0];
            fpsc_pkg::CSR_PRESTREAM:      prestream_ff <= csr_wr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bit_ff       <= '0;
         clk_ff       <= 1'b0;
         count_ff     <= '0;
         code_ff      <= fpsc_pkg::RC_IDLE;
         msel_ff      <= 1'b0;
         early_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            timer_ff <= timer_in;
            bit_ff   <= bit_in;
            clk_ff   <= clk_in;
            count_ff <= count_in;
            code_ff  <= code_in;
            msel_ff  <= msel_in;
            early_ff <= early_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         shift_ff     <= shift_in;
         nconfig_ff   <= nconfig_in;
         dclk_ff      <= dclk_in;
         data_ff      <= data_in;
         msel_out_ff  <= msel_in;
         ready_ff     <= ready_in;
         rcode_ff     <= rcode_in;
         bytes_ff     <= count_in;
         early_out_ff <= early_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nconfig_drive = nconfig_ff;
   assign rsp_dclk_drive    = dclk_ff;
   assign rsp_data_drive    = data_ff;
   assign rsp_msel_enable   = msel_out_ff;
   assign rsp_word_ready    = ready_ff;
   assign rsp_result_code   = rcode_ff;
   assign rsp_bytes_sent    = bytes_ff;
   assign rsp_early_done    = early_out_ff;

   // a start always yields a busy response with the mode pins driven
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == fpsc_pkg::OP_START) |=>
      (rsp_valid && rsp_msel_enable && rsp_result_code == fpsc_pkg::RC_BUSY))
      else $error("start transaction did not give a busy response");

   // nCONFIG pulse only happens with the mode pins driven and during a sequence
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_nconfig_drive) |->
      (rsp_msel_enable && rsp_result_code == fpsc_pkg::RC_BUSY))
      else $error("nconfig pulse outside a running sequence");

   // dclk and word_ready never overlap, and both mean a sequence is running
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_dclk_drive || rsp_word_ready)) |->
      (!(rsp_dclk_drive && rsp_word_ready) && rsp_result_code == fpsc_pkg::RC_BUSY))
      else $error("dclk or word_ready outside a running sequence");

   // a held response freezes the sequencer state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(phase_ff) && $stable(count_ff)))
      else $error("sequencer state moved while the response was stalled");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the passive serial configuration unit. Every
// request transaction is one tick; a scoreboard predicts the pin drives,
// result code and byte count of each response and checks them in order.
// Stimulus is a short directed part followed by mostly well-formed start,
// word and finish sequences with random pin noise, under several timing
// settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

typedef enum logic [3:0] {
   PH_IDLE, PH_SETTLE_PRE, PH_PULSE, PH_CHECK_LOW, PH_WAIT_STATUS, PH_PRESTREAM,
   PH_READY, PH_SHIFT, PH_DRAINED, PH_WAIT_INIT, PH_SETTLE_POST
} seq_phase_type;

typedef struct packed {
   fpsc_pkg::op_type op;
   logic [31:0]      word;
   logic             nstatus;
   logic             confdone;
   logic             initdone;
} tick_type;

typedef struct packed {
   logic               nconfig;
   logic               dclk;
   logic               data;
   logic               msel;
   logic               word_ready;
   fpsc_pkg::code_type code;
   logic [23:0]        bytes;
   logic               early;
} pin_result_type;

class ps_sequence_scoreboard;
   localparam int unsigned TIMER_MAX = 32'h000F_FFFF;
   localparam int unsigned COUNT_MAX = 32'h00FF_FFFF;
   localparam int unsigned WORD_BITS = 32;

   int unsigned        settle, pulse, status_to, init_to, prestream;
   seq_phase_type      ph;
   int unsigned        timer;
   logic [31:0]        shift_word;
   int unsigned        bit_idx;
   bit                 clk_lvl;
   int unsigned        bytes;
   fpsc_pkg::code_type last_code;
   bit                 msel;
   bit                 early;
   pin_result_type     expected_pins[$];
   int                 mismatches;
   int                 checked;

   function new();
      settle = 32'(fpsc_pkg::SETTLE_RESET);
      pulse = 32'(fpsc_pkg::PULSE_RESET);
      status_to = 32'(fpsc_pkg::STATUS_TIMEOUT_RESET);
      init_to = 32'(fpsc_pkg::INIT_TIMEOUT_RESET);
      prestream = 32'(fpsc_pkg::PRESTREAM_RESET);
      ph = PH_IDLE;
      timer = 0;
      shift_word = '0;
      bit_idx = 0;
      clk_lvl = 0;
      bytes = 0;
      last_code = fpsc_pkg::RC_IDLE;
      msel = 0;
      early = 0;
      mismatches = 0;
      checked = 0;
   endfunction

   function void set_register(fpsc_pkg::csr_index_type idx, int unsigned value);
      case (idx)
         fpsc_pkg::CSR_SETTLE:         settle = value & 32'hF_FFFF;
         fpsc_pkg::CSR_PULSE:          pulse = value & 32'hFF;
         fpsc_pkg::CSR_STATUS_TIMEOUT: status_to = value & 32'hFFFF;
         fpsc_pkg::CSR_INIT_TIMEOUT:   init_to = value & 32'hFFFF;
         fpsc_pkg::CSR_PRESTREAM:      prestream = value & 32'hFF;
         default: ;
      endcase
   endfunction

   function bit timer_reaches(int unsigned target);
      if (timer < TIMER_MAX) timer++;
      return timer >= ((target > TIMER_MAX) ? TIMER_MAX : target);
   endfunction

   function void goto_phase(seq_phase_type p);
      ph = p;
      timer = 0;
   endfunction

   function void stop(fpsc_pkg::code_type code);
      ph = PH_IDLE;
      timer = 0;
      clk_lvl = 0;
      last_code = code;
   endfunction

   function void complete();
      msel = 0;
      stop(fpsc_pkg::RC_OK);
   endfunction

   function void attempt_finish(bit confdone);
      if (!confdone) stop(fpsc_pkg::RC_END_ERR);
      else goto_phase(PH_WAIT_INIT);
   endfunction

   // advance one tick and queue the pins expected after it
   function void note_tick(tick_type t);
      pin_result_type r;
      if (t.op == fpsc_pkg::OP_START) begin
         bytes = 0;
         early = 0;
         clk_lvl = 0;
         bit_idx = 0;
         msel = 1;
         goto_phase(settle == 0 ? PH_PULSE : PH_SETTLE_PRE);
      end else begin
         case (ph)
            PH_IDLE: ;
            PH_SETTLE_PRE: if (timer_reaches(settle)) goto_phase(PH_PULSE);
            PH_PULSE: if (timer_reaches(pulse)) goto_phase(PH_CHECK_LOW);
            PH_CHECK_LOW: begin
               if (t.nstatus) stop(fpsc_pkg::RC_START_ERR);
               else goto_phase(PH_WAIT_STATUS);
            end
            PH_WAIT_STATUS: begin
               if (t.nstatus) begin
                  if (t.confdone) stop(fpsc_pkg::RC_START_ERR);
                  else goto_phase(prestream == 0 ? PH_READY : PH_PRESTREAM);
               end else if (timer_reaches(status_to)) begin
                  stop(fpsc_pkg::RC_START_ERR);
               end
            end
            PH_PRESTREAM: if (timer_reaches(prestream)) goto_phase(PH_READY);
            PH_READY: begin
               if (t.op == fpsc_pkg::OP_WORD) begin
                  if (t.confdone) begin
                     if (bytes == 0) begin
                        stop(fpsc_pkg::RC_DATA_ERR);
                     end else begin
                        early = 1;
                        goto_phase(PH_DRAINED);
                     end
                  end else begin
                     shift_word = t.word;
                     bit_idx = 0;
                     clk_lvl = 0;
                     goto_phase(PH_SHIFT);
                  end
               end else if (t.op == fpsc_pkg::OP_FINISH) begin
                  attempt_finish(t.confdone);
               end
            end
            PH_SHIFT: begin
               if (!clk_lvl) begin
                  clk_lvl = 1;
               end else begin
                  clk_lvl = 0;
                  bit_idx++;
                  if (bit_idx >= WORD_BITS) begin
                     bit_idx = 0;
                     if (bytes > COUNT_MAX - WORD_BITS / 8) bytes = COUNT_MAX;
                     else bytes += WORD_BITS / 8;
                     goto_phase(PH_READY);
                  end
               end
            end
            PH_DRAINED: if (t.op == fpsc_pkg::OP_FINISH) attempt_finish(t.confdone);
            PH_WAIT_INIT: begin
               if (t.initdone) begin
                  if (settle == 0) complete();
                  else goto_phase(PH_SETTLE_POST);
               end else if (timer_reaches(init_to)) begin
                  stop(fpsc_pkg::RC_END_ERR);
               end
            end
            PH_SETTLE_POST: if (timer_reaches(settle)) complete();
            default: ph = PH_IDLE;
         endcase
      end
      r.nconfig = (ph != PH_PULSE);
      r.dclk = (ph == PH_SHIFT) ? clk_lvl : 1'b0;
      r.data = (ph == PH_SHIFT && bit_idx < WORD_BITS) ? shift_word[bit_idx[4:0]] : 1'b0;
      r.msel = msel;
      r.word_ready = (ph == PH_READY || ph == PH_DRAINED);
      r.code = (ph == PH_IDLE) ? last_code : fpsc_pkg::RC_BUSY;
      r.bytes = bytes[23:0];
      r.early = early;
      expected_pins.push_back(r);
   endfunction

   function int pending();
      return expected_pins.size();
   endfunction

   function void flush();
      expected_pins.delete();
   endfunction

   task report(string msg);
      if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task compare(string field, logic [23:0] got, logic [23:0] want);
      if (got !== want)
         report($sformatf("transaction %0d %s got %0h expected %0h", checked, field, got,
                          want));
   endtask

   task check_pins(pin_result_type got);
      pin_result_type want;
      if (expected_pins.size() == 0) begin
         report("response with no request pending");
         return;
      end
      want = expected_pins.pop_front();
      compare("nconfig_drive", 24'(got.nconfig), 24'(want.nconfig));
      compare("dclk_drive", 24'(got.dclk), 24'(want.dclk));
      compare("data_drive", 24'(got.data), 24'(want.data));
      compare("msel_enable", 24'(got.msel), 24'(want.msel));
      compare("word_ready", 24'(got.word_ready), 24'(want.word_ready));
      compare("result_code", 24'(got.code), 24'(want.code));
      compare("bytes_sent", got.bytes, want.bytes);
      compare("early_done", 24'(got.early), 24'(want.early));
      checked++;
   endtask
endclass

module tb;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_LIMIT = 5000;
   localparam fpsc_pkg::op_type OP_TICK = 2'd0;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   fpsc_pkg::op_type req_operation = OP_TICK;
   logic [31:0]      req_data_word = '0;
   logic             req_nstatus_level = 1'b0;
   logic             req_confdone_level = 1'b0;
   logic             req_initdone_level = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_nconfig_drive;
   logic             rsp_dclk_drive;
   logic             rsp_data_drive;
   logic             rsp_msel_enable;
   logic             rsp_word_ready;
   logic [2:0]       rsp_result_code;
   logic [23:0]      rsp_bytes_sent;
   logic             rsp_early_done;
   logic             csr_wr_en = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [fpsc_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data = '0;

   pin_result_type observed;
   ps_sequence_scoreboard sb = new();
   int burst_left = 0;
   int words_left = 0;
   int hold_requests = 0;

   fpga_passive_serial_config_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_data_word(req_data_word),
      .req_nstatus_level(req_nstatus_level),
      .req_confdone_level(req_confdone_level),
      .req_initdone_level(req_initdone_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_nconfig_drive(rsp_nconfig_drive),
      .rsp_dclk_drive(rsp_dclk_drive),
      .rsp_data_drive(rsp_data_drive),
      .rsp_msel_enable(rsp_msel_enable),
      .rsp_word_ready(rsp_word_ready),
      .rsp_result_code(rsp_result_code),
      .rsp_bytes_sent(rsp_bytes_sent),
      .rsp_early_done(rsp_early_done),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign observed = {rsp_nconfig_drive, rsp_dclk_drive, rsp_data_drive, rsp_msel_enable,
                      rsp_word_ready, rsp_result_code, rsp_bytes_sent, rsp_early_done};

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_pins(observed);
   end

   initial begin : rsp_stall_pattern
      int span;
      int mode;
      int holds_done;
      span = 0;
      mode = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(3);
               span = $urandom_range(1, 60);
            end
            span--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(3) == 0);
               2: rsp_stall <= ($urandom_range(3) != 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   function automatic tick_type make_tick(fpsc_pkg::op_type op, logic [31:0] word, logic ns,
                                          logic cd, logic id);
      tick_type t;
      t.op = op;
      t.word = word;
      t.nstatus = ns;
      t.confdone = cd;
      t.initdone = id;
      return t;
   endfunction

   // mostly well-formed sequences, steered by the predicted phase
   function automatic tick_type next_tick(int noise_pct);
      tick_type t;
      bit clean;
      t.op = OP_TICK;
      case ($urandom_range(7))
         0: t.word = '0;
         1: t.word = '1;
         default: t.word = $urandom;
      endcase
      t.nstatus = 1'($urandom_range(1));
      t.confdone = 1'($urandom_range(1));
      t.initdone = 1'($urandom_range(1));
      clean = ($urandom_range(99) >= noise_pct);
      case (sb.ph)
         PH_IDLE: begin
            if ($urandom_range(9) < 7) begin
               t.op = fpsc_pkg::OP_START;
               words_left = $urandom_range(1, 4);
            end else begin
               t.op = fpsc_pkg::op_type'($urandom_range(3));
               if (t.op == fpsc_pkg::OP_START) words_left = $urandom_range(1, 4);
            end
         end
         PH_CHECK_LOW: if (clean) t.nstatus = 1'b0;
         PH_WAIT_STATUS: begin
            if (clean) begin
               t.nstatus = ($urandom_range(2) == 0);
               t.confdone = 1'b0;
            end
         end
         PH_READY: begin
            if (words_left > 0) begin
               t.op = fpsc_pkg::OP_WORD;
               words_left--;
               if (clean) t.confdone = (sb.bytes != 0 && $urandom_range(15) == 0);
            end else begin
               t.op = fpsc_pkg::OP_FINISH;
               if (clean) t.confdone = ($urandom_range(9) != 0);
            end
         end
         PH_DRAINED: begin
            t.op = $urandom_range(1) ? fpsc_pkg::OP_FINISH : fpsc_pkg::OP_WORD;
            if (clean) t.confdone = 1'b1;
         end
         PH_WAIT_INIT: if (clean) t.initdone = ($urandom_range(3) == 0);
         default: begin
            // ignored words and finishes while the sequencer is busy
            if ($urandom_range(3) == 0)
               t.op = $urandom_range(1) ? fpsc_pkg::OP_WORD : fpsc_pkg::OP_FINISH;
         end
      endcase
      if ($urandom_range(999) < 2) t.op = fpsc_pkg::OP_START;
      return t;
   endfunction

   task automatic send_tick(tick_type t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= t.op;
      req_data_word <= t.word;
      req_nstatus_level <= t.nstatus;
      req_confdone_level <= t.confdone;
      req_initdone_level <= t.initdone;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_tick(t);
   endtask

   task automatic send_random(int count, int noise_pct);
      for (int i = 0; i < count; i++) send_tick(next_tick(noise_pct));
   endtask

   task automatic drain_responses();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d responses never arrived", sb.pending()));
         sb.flush();
      end
      burst_left = 0;
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timing(int unsigned settle, int unsigned pulse, int unsigned st,
                               int unsigned it, int unsigned pre);
      fpsc_pkg::csr_index_type idx[5];
      int unsigned vals[5];
      idx = '{fpsc_pkg::CSR_SETTLE, fpsc_pkg::CSR_PULSE, fpsc_pkg::CSR_STATUS_TIMEOUT,
              fpsc_pkg::CSR_INIT_TIMEOUT, fpsc_pkg::CSR_PRESTREAM};
      vals = '{settle, pulse, st, it, pre};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wr_data <= vals[i][fpsc_pkg::CSR_DATA_WIDTH-1:0];
         sb.set_register(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: ignored word, then a start left in its long settle
      send_tick(make_tick(OP_TICK, '1, 1'b1, 1'b1, 1'b1));
      send_tick(make_tick(fpsc_pkg::OP_WORD, '1, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(fpsc_pkg::OP_START, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      drain_responses();

      // all waits zero
      write_timing(0, 0, 0, 0, 0);
      // confdone high before the first word
      send_tick(make_tick(fpsc_pkg::OP_START, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b1, 1'b0, 1'b0));
      send_tick(make_tick(fpsc_pkg::OP_WORD, '1, 1'b1, 1'b1, 1'b0));
      // nstatus high right after release
      send_tick(make_tick(fpsc_pkg::OP_START, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b1, 1'b0, 1'b0));
      // zero status timeout
      send_tick(make_tick(fpsc_pkg::OP_START, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      // finish without confdone, then a clean finish
      send_tick(make_tick(fpsc_pkg::OP_START, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b1, 1'b0, 1'b0));
      send_tick(make_tick(fpsc_pkg::OP_FINISH, '0, 1'b1, 1'b0, 1'b1));
      send_tick(make_tick(fpsc_pkg::OP_START, '1, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b0, 1'b0, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b1, 1'b0, 1'b0));
      send_tick(make_tick(fpsc_pkg::OP_FINISH, '0, 1'b1, 1'b1, 1'b0));
      send_tick(make_tick(OP_TICK, '0, 1'b1, 1'b1, 1'b1));
      drain_responses();

      write_timing($urandom_range(1, 20), 1, 1, 1, 255);
      send_random(350, 5);
      drain_responses();

      write_timing(32'hF_FFFF, 255, 65535, 65535, 0);
      send_random(40, 0);
      drain_responses();

      write_timing($urandom_range(0, 30), 255, 65535, 65535, $urandom_range(0, 10));
      send_random(200, 5);
      drain_responses();
      send_random(200, 5);
      drain_responses();

      write_timing($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 12),
                   $urandom_range(0, 12), $urandom_range(0, 6));
      send_random(50, 8);
      hold_requests++;
      burst_left = 2 * LONG_HOLD;
      send_random(450, 8);
      drain_responses();

      write_timing(0, $urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(0, 3));
      send_random(400, 5);
      drain_responses();

      write_timing(32'(fpsc_pkg::SETTLE_RESET), 32'(fpsc_pkg::PULSE_RESET),
                   32'(fpsc_pkg::STATUS_TIMEOUT_RESET), 32'(fpsc_pkg::INIT_TIMEOUT_RESET),
                   32'(fpsc_pkg::PRESTREAM_RESET));
      send_random(60, 5);
      drain_responses();

      repeat (4) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb failed");
      $finish;
   end
endmodule
